// ===== hdl/oale_pkg.sv =====
// Shared types and codes for the ordered array list engine.
// Operation, status and register codes, and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package oale_pkg;

	localparam logic [3:0] OP_READ        = 4'd0;
	localparam logic [3:0] OP_WRITE       = 4'd1;
	localparam logic [3:0] OP_APPEND      = 4'd2;
	localparam logic [3:0] OP_INSERT      = 4'd3;
	localparam logic [3:0] OP_PREPEND     = 4'd4;
	localparam logic [3:0] OP_DELETE      = 4'd5;
	localparam logic [3:0] OP_REMOVE_LAST = 4'd6;
	localparam logic [3:0] OP_FIND        = 4'd7;
	localparam logic [3:0] OP_SEARCH      = 4'd8;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	localparam logic [3:0] REG_CAPACITY = 4'd0;
	localparam logic [3:0] REG_SIGNED   = 4'd1;

	localparam logic [8:0] CAPACITY_RESET = 9'd256;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_READ,
		S_SHUP_MV,
		S_INS_WR,
		S_SHDN_MV,
		S_FIND,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_DONE
	} state_t;

endpackage

// ===== hdl/ordered_array_list_engine_core.sv =====
// Ordered array list engine: element store with fill count, sequenced operations.
// Holds the element memory, the operation sequencer and the result register.
// Depends on oale_pkg.
`timescale 1ns / 1ps

// One operation is taken at a time; in_stall stays high from the accepted beat until the
// sequencer returns to idle. The element memory has one write and one registered read port,
// and all operations run through it and one shared compare unit. Write, append, remove last,
// errors and unused codes go from decode to done; read adds a read state; insert and
// prepend shift up from the end, then write; delete shifts down; find scans; binary
// search alternates read and compare per probe. A finished result sits in the output
// register until taken; the next beat is accepted meanwhile and its result waits behind it.
module ordered_array_list_engine_core #(
	parameter int DEPTH      = 256,
	parameter int ELEM_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  operation,
	input  logic [7:0]  index,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_value,
	output logic [7:0]  found_index,
	output logic        found,
	output logic [1:0]  status,
	output logic [8:0]  element_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	import oale_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = ((CW > 9) ? CW : 9) + 1;

	logic [ELEM_WIDTH-1:0] mem [DEPTH];
	logic [ELEM_WIDTH-1:0] rd_data_q;
	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [AW-1:0]         mem_raddr;
	logic [ELEM_WIDTH-1:0] mem_wdata;

	state_t state_q, state_d;

	logic [3:0]            op_q;
	logic [7:0]            idx_q;
	logic [ELEM_WIDTH-1:0] val_q;

	logic [8:0] capacity_q;
	logic       signed_q;

	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] p_q, p_d;
	logic [CW-1:0] lo_q, lo_d;
	logic [CW-1:0] end_q, end_d;

	logic [1:0]            res_st_q, res_st_d;
	logic                  res_fnd_q, res_fnd_d;
	logic [7:0]            res_fidx_q, res_fidx_d;
	logic [ELEM_WIDTH-1:0] res_rd_q, res_rd_d;

	logic        out_valid_q;
	logic [31:0] read_value_q;
	logic [7:0]  found_index_q;
	logic        found_q;
	logic [1:0]  status_q;
	logic [8:0]  element_count_q;

	logic [XW-1:0] idx_x, ins_x, cnt_x, cap_x, p_x, lo_x, end_x;
	logic [XW-1:0] cnt_m1, p_m1, p_m2, p_p1, p_p2, idx_p1, mid_x;
	logic [1:0]    dec_st;
	logic          key_eq, key_gt, out_load, in_accept;
	logic [ELEM_WIDTH-1:0] sign_mask, key_val, key_elem;

	assign in_accept = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	assign cfg_ready = 1'b1;

	assign idx_x  = XW'(idx_q);
	assign ins_x  = (op_q == OP_PREPEND) ? '0 : idx_x;
	assign cnt_x  = XW'(cnt_q);
	assign cap_x  = (XW'(capacity_q) > XW'(DEPTH)) ? XW'(DEPTH) : XW'(capacity_q);
	assign p_x    = XW'(p_q);
	assign lo_x   = XW'(lo_q);
	assign end_x  = XW'(end_q);
	assign cnt_m1 = cnt_x - XW'(1);
	assign p_m1   = p_x - XW'(1);
	assign p_m2   = p_x - XW'(2);
	assign p_p1   = p_x + XW'(1);
	assign p_p2   = p_x + XW'(2);
	assign idx_p1 = idx_x + XW'(1);
	assign mid_x  = (lo_x + end_x - XW'(1)) >> 1;

	// shared compare unit
	assign sign_mask = ELEM_WIDTH'(1) << (ELEM_WIDTH - 1);
	assign key_val   = signed_q ? (val_q ^ sign_mask) : val_q;
	assign key_elem  = signed_q ? (rd_data_q ^ sign_mask) : rd_data_q;
	assign key_eq    = (rd_data_q == val_q);
	assign key_gt    = (key_val > key_elem);

	always_comb begin
		dec_st = ST_OK;
		case (op_q)
			OP_READ, OP_DELETE: begin
				if (cnt_x == '0) dec_st = ST_EMPTY;
				else if (idx_x >= cnt_x) dec_st = ST_RANGE;
			end
			OP_WRITE: begin
				if (idx_x > cnt_x || idx_x >= cap_x) dec_st = ST_RANGE;
			end
			OP_APPEND: begin
				if (cnt_x >= cap_x) dec_st = ST_FULL;
			end
			OP_INSERT, OP_PREPEND: begin
				if (ins_x > cnt_x) dec_st = ST_RANGE;
				else if (cnt_x >= cap_x) dec_st = ST_FULL;
			end
			OP_REMOVE_LAST, OP_FIND, OP_SEARCH: begin
				if (cnt_x == '0) dec_st = ST_EMPTY;
			end
			default: dec_st = ST_OK;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				if (dec_st != ST_OK) state_d = S_DONE;
				else begin
					case (op_q)
						OP_READ:               state_d = S_READ;
						OP_INSERT, OP_PREPEND: state_d = (ins_x == cnt_x) ? S_DONE : S_SHUP_MV;
						OP_DELETE:             state_d = (idx_p1 >= cnt_x) ? S_DONE : S_SHDN_MV;
						OP_FIND:               state_d = S_FIND;
						OP_SEARCH:             state_d = S_SRCH_RD;
						default:               state_d = S_DONE;
					endcase
				end
			end
			S_READ:     state_d = S_DONE;
			S_SHUP_MV:  state_d = (p_m1 == ins_x) ? S_INS_WR : S_SHUP_MV;
			S_INS_WR:   state_d = S_DONE;
			S_SHDN_MV:  state_d = (p_p2 >= cnt_x) ? S_DONE : S_SHDN_MV;
			S_FIND:     state_d = (key_eq || p_p1 >= cnt_x) ? S_DONE : S_FIND;
			S_SRCH_RD:  state_d = (lo_x >= end_x) ? S_DONE : S_SRCH_CMP;
			S_SRCH_CMP: state_d = key_eq ? S_DONE : S_SRCH_RD;
			S_DONE: begin
				if (out_load) state_d = S_IDLE;
			end
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		mem_we     = 1'b0;
		mem_waddr  = p_q[AW-1:0];
		mem_wdata  = rd_data_q;
		mem_raddr  = '0;
		cnt_d      = cnt_q;
		p_d        = p_q;
		lo_d       = lo_q;
		end_d      = end_q;
		res_st_d   = res_st_q;
		res_fnd_d  = res_fnd_q;
		res_fidx_d = res_fidx_q;
		res_rd_d   = res_rd_q;
		case (state_q)
			S_DECODE: begin
				res_st_d   = dec_st;
				res_fnd_d  = 1'b0;
				res_fidx_d = '0;
				res_rd_d   = '0;
				if (dec_st == ST_OK) begin
					case (op_q)
						OP_READ: mem_raddr = idx_x[AW-1:0];
						OP_WRITE: begin
							mem_we    = 1'b1;
							mem_waddr = idx_x[AW-1:0];
							mem_wdata = val_q;
							if (idx_x == cnt_x) cnt_d = cnt_q + CW'(1);
						end
						OP_APPEND: begin
							mem_we    = 1'b1;
							mem_waddr = cnt_x[AW-1:0];
							mem_wdata = val_q;
							cnt_d     = cnt_q + CW'(1);
						end
						OP_INSERT, OP_PREPEND: begin
							if (ins_x == cnt_x) begin
								mem_we    = 1'b1;
								mem_waddr = ins_x[AW-1:0];
								mem_wdata = val_q;
								cnt_d     = cnt_q + CW'(1);
							end else begin
								p_d       = cnt_q;
								mem_raddr = cnt_m1[AW-1:0];
							end
						end
						OP_DELETE: begin
							if (idx_p1 >= cnt_x) cnt_d = cnt_q - CW'(1);
							else begin
								p_d       = idx_x[CW-1:0];
								mem_raddr = idx_p1[AW-1:0];
							end
						end
						OP_REMOVE_LAST: cnt_d = cnt_q - CW'(1);
						OP_FIND: begin
							p_d       = '0;
							mem_raddr = '0;
						end
						OP_SEARCH: begin
							lo_d  = '0;
							end_d = cnt_q;
						end
						default: cnt_d = cnt_q;
					endcase
				end
			end
			S_READ: res_rd_d = rd_data_q;
			S_SHUP_MV: begin
				mem_we    = 1'b1;
				mem_raddr = p_m2[AW-1:0];
				p_d       = p_m1[CW-1:0];
			end
			S_INS_WR: begin
				mem_we    = 1'b1;
				mem_waddr = ins_x[AW-1:0];
				mem_wdata = val_q;
				cnt_d     = cnt_q + CW'(1);
			end
			S_SHDN_MV: begin
				mem_we = 1'b1;
				if (p_p2 >= cnt_x) cnt_d = cnt_q - CW'(1);
				else begin
					mem_raddr = p_p2[AW-1:0];
					p_d       = p_p1[CW-1:0];
				end
			end
			S_FIND: begin
				if (key_eq) begin
					res_fnd_d  = 1'b1;
					res_fidx_d = 8'(p_q);
				end else begin
					mem_raddr = p_p1[AW-1:0];
					p_d       = p_p1[CW-1:0];
				end
			end
			S_SRCH_RD: begin
				mem_raddr = mid_x[AW-1:0];
				p_d       = mid_x[CW-1:0];
			end
			S_SRCH_CMP: begin
				if (key_eq) begin
					res_fnd_d  = 1'b1;
					res_fidx_d = 8'(p_q);
				end else if (key_gt) lo_d = p_p1[CW-1:0];
				else end_d = p_q;
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rd_data_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			capacity_q  <= CAPACITY_RESET;
			signed_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CAPACITY: capacity_q <= cfg_data[8:0];
					REG_SIGNED:   signed_q   <= cfg_data[0];
					default:      capacity_q <= capacity_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q  <= operation;
			idx_q <= index;
			val_q <= ELEM_WIDTH'(value);
		end
		p_q        <= p_d;
		lo_q       <= lo_d;
		end_q      <= end_d;
		res_st_q   <= res_st_d;
		res_fnd_q  <= res_fnd_d;
		res_fidx_q <= res_fidx_d;
		res_rd_q   <= res_rd_d;
		if (out_load) begin
			read_value_q    <= 32'(res_rd_q);
			found_index_q   <= res_fidx_q;
			found_q         <= res_fnd_q;
			status_q        <= res_st_q;
			element_count_q <= 9'(cnt_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign read_value    = read_value_q;
	assign found_index   = found_index_q;
	assign found         = found_q;
	assign status        = status_q;
	assign element_count = element_count_q;

endmodule

// ===== hdl/oale_chk.sv =====
// Port-level checks for the ordered array list engine.
// Attached to ordered_array_list_engine_core by the bind at the end; uses oale_pkg.
`timescale 1ns / 1ps

module oale_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] read_value,
	input logic [7:0]  found_index,
	input logic        found,
	input logic [1:0]  status,
	input logic [8:0]  element_count
);

	import oale_pkg::*;

	// hold off the next beat once one is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after accepted beat");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && found) |-> (status == ST_OK))
		else $error("found flagged with error status");

	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (found_index == 8'd0))
		else $error("found_index set without a match");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_EMPTY) |-> (element_count == 9'd0))
		else $error("empty status with nonzero count");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(read_value)
			&& $stable(found_index) && $stable(status) && $stable(element_count)))
		else $error("stalled result beat changed");

endmodule

bind ordered_array_list_engine_core oale_chk u_oale_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.read_value    (read_value),
	.found_index   (found_index),
	.found         (found),
	.status        (status),
	.element_count (element_count)
);

// ===== tb/oale_list_checker.sv =====
// Result checker for the ordered array list engine: mirrors the element store and fill count.
// Watches the input, result and register channels, predicts each result and compares it.
// Depends on oale_pkg.
`timescale 1ns / 1ps

module oale_list_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [3:0]  operation,
	input  logic [7:0]  index,
	input  logic [31:0] value,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] read_value,
	input  logic [7:0]  found_index,
	input  logic        found,
	input  logic [1:0]  status,
	input  logic [8:0]  element_count,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          mismatches,
	output int          outstanding,
	output int          checked
);

	import oale_pkg::*;

	localparam int LIST_DEPTH = 256;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic [31:0] rd_value;
		logic [7:0]  hit_index;
		logic        hit;
		logic [1:0]  st;
		logic [8:0]  count;
	} list_result_t;

	logic [31:0]  elem_mirror [LIST_DEPTH];
	int           fill_mirror = 0;
	logic [8:0]   cap_reg = CAPACITY_RESET;
	logic         signed_reg = 1'b0;
	list_result_t pending_results [$];
	int           fail_total = 0;
	int           checked_total = 0;

	function automatic logic [31:0] order_key(input logic [31:0] v);
		return signed_reg ? (v ^ 32'h8000_0000) : v;
	endfunction

	function automatic list_result_t apply_list_op(input logic [3:0] op, input logic [7:0] idx,
			input logic [31:0] val);
		list_result_t r;
		int n, lim, pos, lo, hi, mid;
		logic [31:0] key, probe;
		r = '0;
		n = fill_mirror;
		lim = (cap_reg > LIST_DEPTH) ? LIST_DEPTH : int'(cap_reg);
		case (op)
			OP_READ: begin
				if (n == 0) r.st = ST_EMPTY;
				else if (idx >= n) r.st = ST_RANGE;
				else r.rd_value = elem_mirror[idx];
			end
			OP_WRITE: begin
				if (idx > n || idx >= lim) r.st = ST_RANGE;
				else begin
					elem_mirror[idx] = val;
					if (idx == n) n++;
				end
			end
			OP_APPEND: begin
				if (n >= lim) r.st = ST_FULL;
				else begin
					elem_mirror[n] = val;
					n++;
				end
			end
			OP_INSERT, OP_PREPEND: begin
				pos = (op == OP_PREPEND) ? 0 : int'(idx);
				if (pos > n) r.st = ST_RANGE;
				else if (n >= lim) r.st = ST_FULL;
				else begin
					for (int i = n; i > pos; i--) elem_mirror[i] = elem_mirror[i - 1];
					elem_mirror[pos] = val;
					n++;
				end
			end
			OP_DELETE: begin
				if (n == 0) r.st = ST_EMPTY;
				else if (idx >= n) r.st = ST_RANGE;
				else begin
					for (int i = idx; i + 1 < n; i++) elem_mirror[i] = elem_mirror[i + 1];
					n--;
				end
			end
			OP_REMOVE_LAST: begin
				if (n == 0) r.st = ST_EMPTY;
				else n--;
			end
			OP_FIND: begin
				if (n == 0) r.st = ST_EMPTY;
				else begin
					for (int i = 0; i < n && !r.hit; i++) begin
						if (elem_mirror[i] == val) begin
							r.hit_index = 8'(i);
							r.hit = 1'b1;
						end
					end
				end
			end
			OP_SEARCH: begin
				if (n == 0) r.st = ST_EMPTY;
				else begin
					lo = 0;
					hi = n - 1;
					key = order_key(val);
					while (lo <= hi && !r.hit) begin
						mid = lo + (hi - lo) / 2;
						probe = order_key(elem_mirror[mid]);
						if (key == probe) begin
							r.hit_index = 8'(mid);
							r.hit = 1'b1;
						end else if (key > probe) lo = mid + 1;
						else hi = mid - 1;
					end
				end
			end
			default: ;
		endcase
		fill_mirror = n;
		r.count = 9'(n);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_result_t got, want;
		if (!arst_n) begin
			fill_mirror = 0;
			cap_reg = CAPACITY_RESET;
			signed_reg = 1'b0;
			pending_results.delete();
			fail_total = 0;
			checked_total = 0;
			mismatches <= 0;
			outstanding <= 0;
			checked <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_CAPACITY) cap_reg = cfg_data[8:0];
				else if (cfg_index == REG_SIGNED) signed_reg = cfg_data[0];
			end
			if (out_valid && !out_stall) begin
				got = '{read_value, found_index, found, status, element_count};
				if (pending_results.size() == 0) begin
					fail_total++;
					if (fail_total <= REPORT_MAX)
						$display("unexpected result beat: rd=%h idx=%0d found=%b st=%0d count=%0d",
							got.rd_value, got.hit_index, got.hit, got.st, got.count);
				end else begin
					want = pending_results.pop_front();
					checked_total++;
					if (got.rd_value !== want.rd_value || got.hit_index !== want.hit_index ||
							got.hit !== want.hit || got.st !== want.st ||
							got.count !== want.count) begin
						fail_total++;
						if (fail_total <= REPORT_MAX) begin
							$display("result %0d wrong: want rd=%h idx=%0d found=%b st=%0d count=%0d",
								checked_total, want.rd_value, want.hit_index, want.hit, want.st,
								want.count);
							$display("    got rd=%h idx=%0d found=%b st=%0d count=%0d",
								got.rd_value, got.hit_index, got.hit, got.st, got.count);
						end
					end
				end
			end
			if (in_valid && !in_stall)
				pending_results.push_back(apply_list_op(operation, index, value));
			mismatches <= fail_total;
			outstanding <= pending_results.size();
			checked <= checked_total;
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the ordered array list engine: clock, reset, stimulus and verdict.
// Drives directed and random operations across capacity and ordering settings.
// Depends on oale_pkg, oale_list_checker and ordered_array_list_engine_core.
`timescale 1ns / 1ps

module tb_top;
	import oale_pkg::*;

	localparam int          LIST_DEPTH = 256;
	localparam int          ITEM_GOAL  = 1200;
	localparam int          RUN_LIMIT  = 2000000;
	localparam logic [3:0]  OP_LAST_CODE = 4'd15;
	localparam logic [3:0]  REG_LAST     = 4'd15;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [3:0]  operation = '0;
	logic [7:0]  index = '0;
	logic [31:0] value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] read_value;
	logic [7:0]  found_index;
	logic        found;
	logic [1:0]  status;
	logic [8:0]  element_count;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	int mismatches, outstanding, checked;
	int items_sent = 0;
	int list_len = 0;
	int cur_cap = LIST_DEPTH;
	bit cur_signed = 1'b0;
	bit quiet = 1'b0;
	int hold_left = 0;
	int cycles = 0;

	always #1 clk = ~clk;

	ordered_array_list_engine_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .index(index), .value(value),
		.out_valid(out_valid), .out_stall(out_stall),
		.read_value(read_value), .found_index(found_index), .found(found),
		.status(status), .element_count(element_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	oale_list_checker list_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .index(index), .value(value),
		.out_valid(out_valid), .out_stall(out_stall),
		.read_value(read_value), .found_index(found_index), .found(found),
		.status(status), .element_count(element_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .outstanding(outstanding), .checked(checked)
	);

	function automatic int pace();
		return quiet ? 0 : $urandom_range(0, 13);
	endfunction

	function automatic int cap_eff();
		return (cur_cap > LIST_DEPTH) ? LIST_DEPTH : cur_cap;
	endfunction

	// hold each result beat off for a random number of cycles
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			hold_left = pace();
			out_stall <= (hold_left != 0);
		end else if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_stall <= (hold_left != 0);
		end
	end

	initial begin
		while (cycles < RUN_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	task automatic send_item(input logic [3:0] op, input logic [7:0] idx, input logic [31:0] val);
		int gap;
		gap = pace();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		index <= idx;
		value <= val;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
		case (op)
			OP_WRITE: if (idx == list_len && idx < cap_eff()) list_len++;
			OP_APPEND: if (list_len < cap_eff()) list_len++;
			OP_INSERT: if (idx <= list_len && list_len < cap_eff()) list_len++;
			OP_PREPEND: if (list_len < cap_eff()) list_len++;
			OP_DELETE: if (idx < list_len) list_len--;
			OP_REMOVE_LAST: if (list_len > 0) list_len--;
			default: ;
		endcase
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [3:0] ri, input logic [31:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= ri;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic configure(input int cap, input bit sgn);
		write_reg(REG_CAPACITY, ($urandom & ~32'h1FF) | 32'(cap));
		write_reg(REG_SIGNED, ($urandom & ~32'h1) | 32'(sgn));
		if ($urandom_range(0, 3) == 0)
			write_reg(4'($urandom_range(REG_SIGNED + 1, REG_LAST)), $urandom);
		cfg_valid <= 1'b0;
		cur_cap = cap;
		cur_signed = sgn;
	endtask

	task automatic trim_to(input int limit);
		while (list_len > limit) begin
			if ($urandom_range(0, 1))
				send_item(OP_REMOVE_LAST, 8'($urandom_range(0, 255)), $urandom);
			else send_item(OP_DELETE, 8'($urandom_range(0, list_len - 1)), $urandom);
		end
	endtask

	task automatic run_directed();
		send_item(OP_READ, 8'd0, 32'h0);
		send_item(OP_DELETE, 8'd0, 32'h0);
		send_item(OP_REMOVE_LAST, 8'd0, 32'h0);
		send_item(OP_FIND, 8'd0, 32'h0);
		send_item(OP_SEARCH, 8'd0, 32'h0);
		send_item(OP_WRITE, 8'd1, 32'h5555_5555);
		send_item(OP_WRITE, 8'd0, 32'h0000_0000);
		send_item(OP_APPEND, 8'd0, 32'hFFFF_FFFF);
		send_item(OP_PREPEND, 8'd7, 32'h8000_0000);
		send_item(OP_INSERT, 8'd4, 32'hAAAA_AAAA);
		send_item(OP_INSERT, 8'd3, 32'h7FFF_FFFF);
		send_item(OP_INSERT, 8'd1, 32'h0000_0001);
		send_item(OP_READ, 8'd0, 32'h0);
		send_item(OP_READ, 8'd4, 32'h0);
		send_item(OP_READ, 8'd5, 32'h0);
		send_item(OP_FIND, 8'd0, 32'hFFFF_FFFF);
		send_item(OP_FIND, 8'd0, 32'h1234_5678);
		send_item(OP_WRITE, 8'd5, 32'h0000_0002);
		send_item(OP_WRITE, 8'd2, 32'hFFFF_FFFF);
		send_item(OP_FIND, 8'd0, 32'hFFFF_FFFF);
		send_item(OP_DELETE, 8'd0, 32'h0);
		send_item(OP_DELETE, 8'd5, 32'h0);
		send_item(OP_SEARCH + 4'd1, 8'hFF, 32'hFFFF_FFFF);
		send_item(OP_LAST_CODE, 8'hFF, 32'hFFFF_FFFF);
	endtask

	task automatic mixed_op();
		int pick, hi_idx;
		logic [3:0] op;
		logic [7:0] idx;
		logic [31:0] val;
		pick = $urandom_range(0, 99);
		if (pick < 12) op = OP_READ;
		else if (pick < 24) op = OP_WRITE;
		else if (pick < 38) op = OP_APPEND;
		else if (pick < 50) op = OP_INSERT;
		else if (pick < 56) op = OP_PREPEND;
		else if (pick < 68) op = OP_DELETE;
		else if (pick < 74) op = OP_REMOVE_LAST;
		else if (pick < 85) op = OP_FIND;
		else if (pick < 96) op = OP_SEARCH;
		else op = 4'($urandom_range(OP_SEARCH + 1, OP_LAST_CODE));
		hi_idx = (list_len > 255) ? 255 : list_len;
		if ($urandom_range(0, 6) == 0) idx = 8'($urandom_range(0, 255));
		else idx = 8'($urandom_range(0, hi_idx));
		case ($urandom_range(0, 3))
			0: val = $urandom_range(0, 7);
			1: begin
				case ($urandom_range(0, 3))
					0: val = 32'h0000_0000;
					1: val = 32'hFFFF_FFFF;
					2: val = 32'h8000_0000;
					default: val = 32'h7FFF_FFFF;
				endcase
			end
			default: val = $urandom;
		endcase
		send_item(op, idx, val);
	endtask

	// ascending list under the current ordering, then probe it
	task automatic sorted_search_run();
		logic [31:0] key;
		logic [31:0] stored [$];
		int n, k;
		trim_to(0);
		n = (cap_eff() < 24) ? cap_eff() : 24;
		if (n > 0) n = $urandom_range(1, n);
		key = $urandom >> 2;
		for (k = 0; k < n; k++) begin
			key = key + $urandom_range(0, 1 << 24);
			stored.push_back(cur_signed ? (key ^ 32'h8000_0000) : key);
			send_item(OP_APPEND, 8'($urandom_range(0, 255)), stored[k]);
		end
		for (k = 0; k < 3 * n + 4; k++) begin
			case ($urandom_range(0, 3))
				0, 1: send_item(OP_SEARCH, 8'($urandom_range(0, 255)),
					(n > 0) ? stored[$urandom_range(0, n - 1)] : $urandom);
				2: send_item(OP_SEARCH, 8'($urandom_range(0, 255)), $urandom);
				default: send_item(OP_FIND, 8'($urandom_range(0, 255)),
					(n > 0) ? stored[$urandom_range(0, n - 1)] : $urandom);
			endcase
		end
	endtask

	// fill to the full depth and work the top index
	task automatic fill_run();
		while (list_len < cap_eff())
			send_item(OP_APPEND, 8'($urandom_range(0, 255)), $urandom);
		send_item(OP_APPEND, 8'd0, $urandom);
		send_item(OP_INSERT, 8'd255, $urandom);
		send_item(OP_WRITE, 8'd255, $urandom);
		send_item(OP_READ, 8'd255, 32'h0);
		send_item(OP_FIND, 8'd0, $urandom);
		send_item(OP_SEARCH, 8'd0, $urandom);
		send_item(OP_DELETE, 8'd255, 32'h0);
		send_item(OP_PREPEND, 8'd0, $urandom);
		send_item(OP_DELETE, 8'd0, 32'h0);
	endtask

	initial begin
		int phase, cap, pick, len;
		bit sgn;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (phase = 0; items_sent < ITEM_GOAL; phase++) begin
			drain();
			case (phase)
				0: cap = 256;
				1: cap = 1;
				2: cap = 0;
				3: cap = 2;
				4: cap = 300;
				5: cap = 511;
				6: cap = 255;
				7: cap = 16;
				default: begin
					pick = $urandom_range(0, 9);
					if (pick < 7) cap = $urandom_range(1, 48);
					else if (pick < 9) cap = $urandom_range(49, 256);
					else cap = $urandom_range(257, 511);
				end
			endcase
			sgn = (phase < 8) ? phase[0] : 1'($urandom_range(0, 1));
			configure(cap, sgn);
			quiet = (phase % 3 == 2);
			trim_to(cap_eff());
			if (phase == 4) fill_run();
			else if (phase % 4 == 1) sorted_search_run();
			else begin
				len = $urandom_range(40, 90);
				repeat (len) mixed_op();
			end
		end
		drain();
		repeat (300) @(posedge clk);
		$display("Ran %0d operations over %0d register phases, capacity 0 to 511, both orderings.",
			items_sent, phase);
		$display("Compared %0d result beats: %0d mismatches, %0d still awaited.",
			checked, mismatches, outstanding);
		if (mismatches == 0 && outstanding == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

endmodule
